@@ src/crp_pkg.sv @@
// Shared types, constants and codes for the command ring producer.
// Depends on nothing; every other file in src imports it.
package crp_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int MAX_PAD = 64;

	localparam int PTR_W = 64;
	localparam int IDX_W = 10;
	localparam int WORD_W = 32;
	localparam int REQ_W = 16;
	localparam int CNT_W = 7;
	localparam int MASK_W = 6;
	localparam int LIMIT_W = 16;
	localparam int LEFT_W = $clog2(MAX_PAD + 1);

	localparam logic [PTR_W-1:0] RING_MASK = PTR_W'(RING_DEPTH - 1);
	localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = LIMIT_W'(1024);

	typedef enum logic [2:0] {
		OP_RESERVE = 3'd0,
		OP_WRITE   = 3'd1,
		OP_NOPS    = 3'd2,
		OP_COMMIT  = 3'd3,
		OP_UNDO    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_STORE   = 2'd0,
		KIND_PUBLISH = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_PACKET_MODE  = 3'd0,
		REG_NOP_WORD     = 3'd1,
		REG_PACKET_NOP   = 3'd2,
		REG_PLAIN_ALIGN  = 3'd3,
		REG_PACKET_ALIGN = 3'd4,
		REG_FRAME_LIMIT  = 3'd5,
		REG_WIDE_POINTER = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_STORE,
		S_TAIL
	} state_t;

	// What follows the stores of an item.
	typedef enum logic [2:0] {
		T_NONE,
		T_STATUS,
		T_RESERVE,
		T_PUBLISH,
		T_UNDO
	} tail_t;

	typedef struct packed {
		logic                packet_mode;
		logic [WORD_W-1:0]   nop_word;
		logic [WORD_W-1:0]   packet_nop_word;
		logic [MASK_W-1:0]   plain_align_mask;
		logic [MASK_W-1:0]   packet_align_mask;
		logic [LIMIT_W-1:0]  frame_limit;
		logic                wide_pointer;
	} cfg_t;

	typedef struct packed {
		logic [PTR_W-1:0]  next_ptr;
		logic [IDX_W-1:0]  index;
		logic              overrun;
		logic [REQ_W-1:0]  next_remaining;
	} step_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   store_index;
		logic [WORD_W-1:0]  store_word;
		logic               overrun;
		logic [PTR_W-1:0]   write_pointer;
		logic               status;
		logic               last;
	} res_t;

endpackage

@@ src/command_ring_producer.sv @@
// Command ring producer: an input item is taken while the block is idle; its first
// result item passes the state register and then the output register, then one leaves
// per cycle the output allows. An item with N results keeps the block from taking the
// next item until all N are emitted (N up to 64 for a NOP insert, up to 64 for a
// commit with its pads); the shared store step advances the pointer once per store.
// Reset clears the pointers, the reserved count and the output valid flag.
module command_ring_producer (
	input  logic          clk,
	input  logic          arst_n,
	// Input item stream.
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [55:0]   s_tdata,   // data_word[31:0], request_words[47:32],
	                                 // nop_count[54:48], zero fill
	input  logic [2:0]    s_tuser,   // operation[2:0]
	// Result item stream.
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // store_index[9:0], store_word[41:10],
	                                 // overrun[42], write_pointer[106:43],
	                                 // status[107], zero fill
	output logic [1:0]    m_tuser,   // kind[1:0]
	output logic          m_tlast,   // final result item of the input item
	// Configuration write channel.
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import crp_pkg::*;

	cfg_t cfg;
	res_t res;

	// Registers are always writable; software must write them only while the block is
	// idle so that no item sees a half-changed mode; the block does not enforce this.
	assign cfg_ready = 1'b1;

	crp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer decodes each item into a run of ring stores followed,
	// where the operation calls for it, by one publish or status item. Each
	// store advances the write pointer through the shared step unit.
	crp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_data   (s_tdata[31:0]),
		.in_req    (s_tdata[47:32]),
		.in_cnt    (s_tdata[54:48]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack the result item onto the stream, lowest field first.
	assign m_tdata = {4'b0, res.status, res.write_pointer, res.overrun,
		res.store_word, res.store_index};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

@@ src/crp_cfg.sv @@
// Configuration register file of the command ring producer.
// Depends on crp_pkg for the register codes and the cfg_t bundle.
module crp_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output crp_pkg::cfg_t        cfg
);
	import crp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{packet_mode: 1'b0, nop_word: '0, packet_nop_word: '0,
				plain_align_mask: '0, packet_align_mask: '0,
				frame_limit: FRAME_LIMIT_RST, wide_pointer: 1'b0};
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PACKET_MODE:  cfg_q.packet_mode <= cfg_data[0];
				REG_NOP_WORD:     cfg_q.nop_word <= cfg_data;
				REG_PACKET_NOP:   cfg_q.packet_nop_word <= cfg_data;
				REG_PLAIN_ALIGN:  cfg_q.plain_align_mask <= cfg_data[MASK_W-1:0];
				REG_PACKET_ALIGN: cfg_q.packet_align_mask <= cfg_data[MASK_W-1:0];
				REG_FRAME_LIMIT:  cfg_q.frame_limit <= cfg_data[LIMIT_W-1:0];
				REG_WIDE_POINTER: cfg_q.wide_pointer <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/crp_step.sv @@
// Shared store step: slot index, pointer advance with optional wrap and
// reservation count-down for one ring store. Depends on crp_pkg.
module crp_step (
	input  logic [63:0]          ptr,
	input  logic                 wide,
	input  logic [15:0]          remaining,
	output crp_pkg::step_t       step
);
	import crp_pkg::*;

	logic [PTR_W-1:0] inc;

	always_comb begin
		inc = ptr + PTR_W'(1);
		step.index = IDX_W'(ptr & RING_MASK);
		step.next_ptr = wide ? inc : (inc & RING_MASK);
		step.overrun = (remaining == '0);
		step.next_remaining = (remaining == '0) ? '0 : remaining - REQ_W'(1);
	end

endmodule

@@ src/crp_seq.sv @@
// Sequencer of the command ring producer: holds the ring state, steps the
// shared store unit once per store result and keeps the output register.
// Depends on crp_pkg and crp_step.
module crp_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crp_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           in_op,
	input  logic [31:0]          in_data,
	input  logic [15:0]          in_req,
	input  logic [6:0]           in_cnt,
	output logic                 out_valid,
	input  logic                 out_ready,
	output crp_pkg::res_t        out_res
);
	import crp_pkg::*;

	state_t state_q, state_d;
	tail_t tail_q, tail_init;
	logic [LEFT_W-1:0] left_q, left_init;
	logic [WORD_W-1:0] word_q, word_init;
	logic [REQ_W-1:0] req_q;
	logic [PTR_W-1:0] write_ptr_q, saved_ptr_q;
	logic [REQ_W-1:0] remaining_q;
	logic out_valid_q;
	res_t res_q;

	logic accept, out_free, emit_store, emit_tail;
	logic [MASK_W-1:0] cur_mask, ptr_low;
	logic [WORD_W-1:0] cur_nop;
	logic [LEFT_W-1:0] pad, nop_sat;
	logic [REQ_W:0] rsv_sum, rsv_words;
	logic rsv_ok;
	step_t step;

	crp_step u_step (
		.ptr       (write_ptr_q),
		.wide      (cfg.wide_pointer),
		.remaining (remaining_q),
		.step      (step)
	);

	always_comb begin
		cur_mask = cfg.packet_mode ? cfg.packet_align_mask : cfg.plain_align_mask;
		cur_nop = cfg.packet_mode ? cfg.packet_nop_word : cfg.nop_word;
		ptr_low = write_ptr_q[MASK_W-1:0] & cur_mask;
		// Words up to the next aligned slot; nothing when already aligned.
		pad = (ptr_low == '0) ? '0
			: LEFT_W'({1'b0, cur_mask}) + LEFT_W'(1) - LEFT_W'({1'b0, ptr_low});
		nop_sat = (in_cnt > CNT_W'(MAX_PAD)) ? LEFT_W'(MAX_PAD) : LEFT_W'(in_cnt);
		rsv_sum = {1'b0, req_q} + (REQ_W+1)'(cur_mask);
		rsv_words = rsv_sum & ~((REQ_W+1)'(cur_mask));
		rsv_ok = rsv_words <= {1'b0, cfg.frame_limit};
	end

	// Decode of an incoming item into a store count, fill word and tail.
	always_comb begin
		left_init = '0;
		word_init = cur_nop;
		tail_init = T_STATUS;
		unique case (in_op)
			OP_RESERVE: tail_init = T_RESERVE;
			OP_WRITE: begin
				left_init = LEFT_W'(1);
				word_init = in_data;
				tail_init = T_NONE;
			end
			OP_NOPS: begin
				left_init = nop_sat;
				tail_init = (nop_sat == '0) ? T_STATUS : T_NONE;
			end
			OP_COMMIT: begin
				left_init = pad;
				tail_init = T_PUBLISH;
			end
			OP_UNDO: tail_init = T_UNDO;
			default: tail_init = T_STATUS;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = (left_init != '0) ? S_STORE : S_TAIL;
			end
			S_STORE: begin
				if (out_free && left_q == LEFT_W'(1))
					state_d = (tail_q == T_NONE) ? S_IDLE : S_TAIL;
			end
			S_TAIL: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_free = !out_valid_q || out_ready;
		in_ready = (state_q == S_IDLE);
		accept = in_valid && in_ready;
		emit_store = (state_q == S_STORE) && out_free;
		emit_tail = (state_q == S_TAIL) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			write_ptr_q <= '0;
			saved_ptr_q <= '0;
			remaining_q <= '0;
			left_q <= '0;
			tail_q <= T_NONE;
		end else begin
			state_q <= state_d;
			if (emit_store || emit_tail)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				left_q <= left_init;
				tail_q <= tail_init;
			end
			if (emit_store) begin
				left_q <= left_q - LEFT_W'(1);
				write_ptr_q <= step.next_ptr;
				remaining_q <= step.next_remaining;
			end
			if (emit_tail && tail_q == T_RESERVE && rsv_ok) begin
				remaining_q <= rsv_words[REQ_W-1:0];
				saved_ptr_q <= write_ptr_q;
			end
			if (emit_tail && tail_q == T_UNDO)
				write_ptr_q <= saved_ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_init;
			req_q <= in_req;
		end
		if (emit_store) begin
			res_q.kind <= KIND_STORE;
			res_q.store_index <= step.index;
			res_q.store_word <= word_q;
			res_q.overrun <= step.overrun;
			res_q.write_pointer <= step.next_ptr;
			res_q.status <= 1'b0;
			res_q.last <= (left_q == LEFT_W'(1)) && (tail_q == T_NONE);
		end else if (emit_tail) begin
			res_q.kind <= (tail_q == T_PUBLISH) ? KIND_PUBLISH : KIND_STATUS;
			res_q.store_index <= '0;
			res_q.store_word <= '0;
			res_q.overrun <= 1'b0;
			res_q.write_pointer <= (tail_q == T_UNDO) ? saved_ptr_q : write_ptr_q;
			res_q.status <= (tail_q == T_RESERVE) && !rsv_ok;
			res_q.last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = res_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the command ring producer: drives command items and register
// writes, and checks every result item against a behavioural copy or a typed-in result.
// Depends on crp_pkg and command_ring_producer from src.
module testbench;
	import crp_pkg::*;

	// Operation codes 5 to 7 have no meaning and give a single status result.
	localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

	localparam int IDLE_PCT      = 27;
	localparam int CALM_FROM     = 150;     // accepted items, start of the no-idle stretch
	localparam int CALM_TO       = 200;
	localparam int HOLD_AT       = 90;      // accepted items before the long output stall
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS   = 32;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SHOWN_LIMIT   = 10;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [55:0]   s_tdata;   // data_word[31:0], request_words[47:32], nop_count[54:48]
	logic [2:0]    s_tuser;   // operation[2:0]
	logic          m_tvalid;
	logic          m_tready;
	logic [111:0]  m_tdata;   // store_index[9:0], store_word[41:10], overrun[42],
	                          // write_pointer[106:43], status[107]
	logic [1:0]    m_tuser;   // kind[1:0]
	logic          m_tlast;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;

	command_ring_producer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Behavioural copy of the producer: registers, pointers and reserved count.
	cfg_t         regs;
	logic [63:0]  ring_ptr;
	logic [63:0]  ring_saved;
	logic [15:0]  words_left;
	res_t         due_results[$];

	int mismatches = 0;
	int accepted_items = 0;
	int cycle_count = 0;

	// One row of the directed script: a register write or a command item, the latter
	// optionally with its single result typed in by hand.
	typedef struct packed {
		logic        is_reg;
		cfg_reg_t    reg_index;
		logic [31:0] value;     // register value, or data_word of an item
		logic [2:0]  op;
		logic [15:0] req;
		logic [6:0]  cnt;
		logic        typed;
		res_t        want;
	} script_row_t;

	script_row_t script[$];

	function automatic script_row_t item_row(input logic [2:0] op, input logic [31:0] data,
			input logic [15:0] req, input logic [6:0] cnt);
		script_row_t row;
		row = '0;
		row.op = op;
		row.value = data;
		row.req = req;
		row.cnt = cnt;
		return row;
	endfunction

	function automatic script_row_t typed_row(input logic [2:0] op, input logic [31:0] data,
			input logic [15:0] req, input logic [6:0] cnt, input kind_t kind,
			input logic [9:0] idx, input logic [31:0] word, input logic ovr,
			input logic [63:0] ptr, input logic st);
		script_row_t row;
		row = item_row(op, data, req, cnt);
		row.typed = 1'b1;
		row.want.kind = kind;
		row.want.store_index = idx;
		row.want.store_word = word;
		row.want.overrun = ovr;
		row.want.write_pointer = ptr;
		row.want.status = st;
		row.want.last = 1'b1;
		return row;
	endfunction

	function automatic script_row_t reg_row(input cfg_reg_t idx, input logic [31:0] value);
		script_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_index = idx;
		row.value = value;
		return row;
	endfunction

	// A store writes at the pointer masked to the ring, then advances the pointer. The
	// reserved count never goes below zero; a store with nothing reserved is an overrun.
	task automatic ring_store(input logic [31:0] word);
		res_t r;
		r = '0;
		r.kind = KIND_STORE;
		r.store_index = IDX_W'(ring_ptr & RING_MASK);
		r.store_word = word;
		r.overrun = (words_left == '0);
		ring_ptr = ring_ptr + 64'd1;
		if (!regs.wide_pointer)
			ring_ptr = ring_ptr & RING_MASK;
		if (words_left != '0)
			words_left = words_left - 16'd1;
		r.write_pointer = ring_ptr;
		due_results.push_back(r);
	endtask

	// A result that only reports the pointer: status, or the publish of a commit.
	task automatic post_pointer(input kind_t kind, input logic st);
		res_t r;
		r = '0;
		r.kind = kind;
		r.write_pointer = ring_ptr;
		r.status = st;
		due_results.push_back(r);
	endtask

	// Works out every result of one command item and queues them in order.
	task automatic apply_command(input logic [2:0] op, input logic [31:0] data,
			input logic [15:0] req, input logic [6:0] cnt);
		logic [5:0]  mask;
		logic [31:0] filler;
		logic [16:0] rounded;
		int          n;
		res_t        r;
		mask = regs.packet_mode ? regs.packet_align_mask : regs.plain_align_mask;
		filler = regs.packet_mode ? regs.packet_nop_word : regs.nop_word;
		case (op)
			OP_RESERVE: begin
				// Seventeen bits, so that rounding the largest request up cannot wrap.
				rounded = (17'(req) + 17'(mask)) & ~17'(mask);
				if (rounded <= 17'(regs.frame_limit)) begin
					words_left = rounded[15:0];
					ring_saved = ring_ptr;
					post_pointer(KIND_STATUS, 1'b0);
				end else begin
					post_pointer(KIND_STATUS, 1'b1);
				end
			end
			OP_WRITE: ring_store(data);
			OP_NOPS: begin
				n = (int'(cnt) > MAX_PAD) ? MAX_PAD : int'(cnt);
				if (n == 0)
					post_pointer(KIND_STATUS, 1'b0);
				else
					repeat (n) ring_store(filler);
			end
			OP_COMMIT: begin
				n = (int'(mask) + 1 - int'(ring_ptr[5:0] & mask)) % (int'(mask) + 1);
				repeat (n) ring_store(filler);
				post_pointer(KIND_PUBLISH, 1'b0);
			end
			OP_UNDO: begin
				ring_ptr = ring_saved;
				post_pointer(KIND_STATUS, 1'b0);
			end
			default: post_pointer(KIND_STATUS, 1'b0);
		endcase
		r = due_results.pop_back();
		r.last = 1'b1;
		due_results.push_back(r);
	endtask

	function automatic bit calm();
		return accepted_items >= CALM_FROM && accepted_items < CALM_TO;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= SHOWN_LIMIT)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	task automatic compare_result(input res_t got);
		res_t want;
		if (due_results.size() == 0) begin
			flag_mismatch("result with nothing due, pointer", 64'd0, got.write_pointer);
			return;
		end
		want = due_results.pop_front();
		if (got.kind !== want.kind)
			flag_mismatch("kind", 64'(want.kind), 64'(got.kind));
		if (got.store_index !== want.store_index)
			flag_mismatch("store_index", 64'(want.store_index), 64'(got.store_index));
		if (got.store_word !== want.store_word)
			flag_mismatch("store_word", 64'(want.store_word), 64'(got.store_word));
		if (got.overrun !== want.overrun)
			flag_mismatch("overrun", 64'(want.overrun), 64'(got.overrun));
		if (got.write_pointer !== want.write_pointer)
			flag_mismatch("write_pointer", want.write_pointer, got.write_pointer);
		if (got.status !== want.status)
			flag_mismatch("status", 64'(want.status), 64'(got.status));
		if (got.last !== want.last)
			flag_mismatch("last", 64'(want.last), 64'(got.last));
	endtask

	// Both handshakes are sampled in the active region of the rising edge, before any
	// nonblocking update of that edge lands, so they see the values the block saw.
	always @(posedge clk) begin : result_monitor
		res_t got;
		if (arst_n && s_tvalid && s_tready)
			accepted_items <= accepted_items + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser);
			got.store_index = m_tdata[9:0];
			got.store_word = m_tdata[41:10];
			got.overrun = m_tdata[42];
			got.write_pointer = m_tdata[106:43];
			got.status = m_tdata[107];
			got.last = m_tlast;
			compare_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Output side: random stalls, none inside the calm stretch, and once a long hold-off
	// while the input side keeps offering, so that the block backs up and stalls its input.
	initial begin : result_sink
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_items >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm()) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offers one item, with random gaps before it, and books its results once accepted.
	task automatic send_item(input logic [2:0] op, input logic [31:0] data,
			input logic [15:0] req, input logic [6:0] cnt);
		while (!calm() && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, cnt, req, data};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(op, data, req, cnt);
	endtask

	// Stops offering and waits until every booked result has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_PACKET_MODE:  regs.packet_mode = value[0];
			REG_NOP_WORD:     regs.nop_word = value;
			REG_PACKET_NOP:   regs.packet_nop_word = value;
			REG_PLAIN_ALIGN:  regs.plain_align_mask = value[MASK_W-1:0];
			REG_PACKET_ALIGN: regs.packet_align_mask = value[MASK_W-1:0];
			REG_FRAME_LIMIT:  regs.frame_limit = value[LIMIT_W-1:0];
			REG_WIDE_POINTER: regs.wide_pointer = value[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic pm, input logic [31:0] nop, input logic [31:0] pnop,
			input logic [5:0] plain_mask, input logic [5:0] pkt_mask,
			input logic [15:0] limit, input logic wide);
		drain();
		write_reg(REG_PACKET_MODE, 32'(pm));
		write_reg(REG_NOP_WORD, nop);
		write_reg(REG_PACKET_NOP, pnop);
		write_reg(REG_PLAIN_ALIGN, 32'(plain_mask));
		write_reg(REG_PACKET_ALIGN, 32'(pkt_mask));
		write_reg(REG_FRAME_LIMIT, 32'(limit));
		write_reg(REG_WIDE_POINTER, 32'(wide));
	endtask

	// Mostly well-formed frames (reserve, a run of writes, perhaps some NOPs, then commit
	// or undo) with random content; about one draw in five sends a single random noise item.
	task automatic run_phase(input int quota);
		int sent;
		int words;
		int k;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 20) begin
				send_item(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 7'($urandom));
				sent++;
			end else begin
				words = $urandom_range(0, 24);
				send_item(OP_RESERVE, $urandom, 16'(words), 7'($urandom));
				// Writing a little past the reservation provokes overruns.
				k = $urandom_range(0, words + 2);
				repeat (k) send_item(OP_WRITE, $urandom, 16'($urandom), 7'($urandom));
				sent += k + 1;
				if ($urandom_range(3) == 0) begin
					if ($urandom_range(9) == 0)
						send_item(OP_NOPS, $urandom, 16'($urandom), 7'($urandom_range(40, 127)));
					else
						send_item(OP_NOPS, $urandom, 16'($urandom), 7'($urandom_range(0, 8)));
					sent++;
				end
				if ($urandom_range(4) == 0)
					send_item(OP_UNDO, $urandom, 16'($urandom), 7'($urandom));
				else
					send_item(OP_COMMIT, $urandom, 16'($urandom), 7'($urandom));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs = '0;
		regs.frame_limit = FRAME_LIMIT_RST;
		ring_ptr = '0;
		ring_saved = '0;
		words_left = '0;

		// Reset values: no alignment, NOP word zero, frame limit 1024, ring-wrapped pointer.
		// Typed rows hold results that follow straight from those values.
		script.push_back(typed_row(OP_UNDO, 32'h0, 16'h0, 7'h0,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd0, 1'b0));
		script.push_back(typed_row(OP_WRITE, 32'hFFFF_FFFF, 16'h0, 7'h0,
			KIND_STORE, 10'd0, 32'hFFFF_FFFF, 1'b1, 64'd1, 1'b0));
		script.push_back(typed_row(OP_RESERVE, 32'h0, 16'd1025, 7'h0,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd1, 1'b1));
		script.push_back(typed_row(OP_RESERVE, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd1, 1'b1));
		script.push_back(typed_row(OP_RESERVE, 32'h0, 16'd1024, 7'h0,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd1, 1'b0));
		script.push_back(typed_row(OP_WRITE, 32'h0, 16'hFFFF, 7'h7F,
			KIND_STORE, 10'd1, 32'h0, 1'b0, 64'd2, 1'b0));
		script.push_back(typed_row(OP_UNKNOWN_HI, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd2, 1'b0));
		script.push_back(item_row(OP_UNKNOWN_LO, 32'h1234_5678, 16'h0, 7'h0));
		script.push_back(typed_row(OP_NOPS, 32'h0, 16'h0, 7'd0,
			KIND_STATUS, 10'd0, 32'h0, 1'b0, 64'd2, 1'b0));
		// A count above the pad limit is clipped to it.
		script.push_back(item_row(OP_NOPS, 32'h0, 16'h0, 7'd127));
		script.push_back(item_row(OP_NOPS, 32'h0, 16'h0, 7'd64));
		script.push_back(item_row(OP_NOPS, 32'h0, 16'h0, 7'd1));
		script.push_back(item_row(OP_COMMIT, 32'h0, 16'h0, 7'h0));
		script.push_back(item_row(OP_UNDO, 32'h0, 16'h0, 7'h0));
		// Plain alignment of eight: the commit has to pad.
		script.push_back(reg_row(REG_NOP_WORD, 32'hA5A5_A5A5));
		script.push_back(reg_row(REG_PLAIN_ALIGN, 32'd7));
		script.push_back(reg_row(REG_FRAME_LIMIT, 32'd16));
		script.push_back(item_row(OP_RESERVE, 32'h0, 16'd9, 7'h0));
		script.push_back(item_row(OP_WRITE, 32'h0000_0001, 16'h0, 7'h0));
		script.push_back(item_row(OP_WRITE, 32'h0000_0002, 16'h0, 7'h0));
		script.push_back(item_row(OP_WRITE, 32'h0000_0003, 16'h0, 7'h0));
		script.push_back(item_row(OP_COMMIT, 32'h0, 16'h0, 7'h0));
		// Packet mode with a mask that is not one less than a power of two, wide pointer.
		script.push_back(reg_row(REG_PACKET_MODE, 32'd1));
		script.push_back(reg_row(REG_PACKET_NOP, 32'h5A5A_5A5A));
		script.push_back(reg_row(REG_PACKET_ALIGN, 32'h2A));
		script.push_back(reg_row(REG_WIDE_POINTER, 32'd1));
		script.push_back(item_row(OP_RESERVE, 32'h0, 16'd0, 7'h0));
		script.push_back(item_row(OP_WRITE, 32'hDEAD_BEEF, 16'h0, 7'h0));
		script.push_back(item_row(OP_COMMIT, 32'h0, 16'h0, 7'h0));
		script.push_back(item_row(OP_RESERVE, 32'h0, 16'd17, 7'h0));
		script.push_back(item_row(OP_NOPS, 32'h0, 16'h0, 7'd65));
		script.push_back(item_row(OP_COMMIT, 32'h0, 16'h0, 7'h0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				drain();
				write_reg(script[i].reg_index, script[i].value);
			end else begin
				send_item(script[i].op, script[i].value, script[i].req, script[i].cnt);
				if (script[i].typed) begin
					void'(due_results.pop_back());
					due_results.push_back(script[i].want);
				end
			end
		end

		// Each phase change waits for every booked result first, so the input side pauses
		// with the block empty at least once per phase.
		set_regs(1'b0, 32'h8000_0001, 32'h7FFF_FFFE, 6'd3, 6'd7, 16'd1024, 1'b0);
		// Run the pointer up to the end of the ring so that it wraps in this phase.
		while (ring_ptr < 64'd1000)
			send_item(OP_NOPS, $urandom, 16'($urandom), 7'd64);
		run_phase(PHASE_ITEMS);
		set_regs(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 6'd63, 16'hFFFF, 1'b1);
		run_phase(PHASE_ITEMS);
		// A frame limit of zero lets only empty reservations through.
		set_regs(1'b0, $urandom, $urandom, 6'h2A, 6'h3F, 16'd0, 1'b0);
		run_phase(PHASE_ITEMS);
		set_regs(1'b1, $urandom, $urandom, 6'($urandom), 6'd15,
			16'($urandom_range(16, 200)), 1'($urandom_range(0, 1)));
		run_phase(PHASE_ITEMS);
		set_regs(1'b0, 32'h0, 32'hFFFF_FFFF, 6'd31, 6'd1, 16'd1, 1'b0);
		run_phase(PHASE_ITEMS);

		drain();
		if (mismatches == 0 && due_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
